FILE: src/ifsu_pkg.sv
`timescale 1ns / 1ps

package ifsu_pkg;

   localparam int unsigned CSR_DATA_W = 4;

   localparam logic [1:0] MODE_INT8    = 2'd0;
   localparam logic [1:0] MODE_COMPLEX = 2'd1;
   localparam logic [1:0] MODE_PACK2   = 2'd2;
   localparam logic [1:0] MODE_PACK4   = 2'd3;

   localparam logic CSR_FORMAT_MODE = 1'b0;
   localparam logic CSR_I_ONLY_MASK = 1'b1;

   localparam logic [2:0] CHAN_COUNT_ONE  = 3'd1;
   localparam logic [2:0] CHAN_COUNT_TWO  = 3'd2;
   localparam logic [2:0] CHAN_COUNT_FOUR = 3'd4;

   typedef struct packed {
      logic [7:0] raw_first;
      logic [7:0] raw_second;
   } req_type;

   typedef struct packed {
      logic signed [7:0] ch0_i;
      logic signed [7:0] ch0_q;
      logic signed [7:0] ch1_i;
      logic signed [7:0] ch1_q;
      logic signed [7:0] ch2_i;
      logic signed [7:0] ch2_q;
      logic signed [7:0] ch3_i;
      logic signed [7:0] ch3_q;
      logic [2:0]        channel_count;
   } rsp_type;

   // 2-bit I code: +1, +3, -1, -3
   function automatic logic signed [7:0] code_to_i(input logic [1:0] code);
      logic signed [7:0] val;
      case (code)
         2'd0:    val = 8'sd1;
         2'd1:    val = 8'sd3;
         2'd2:    val = -8'sd1;
         default: val = -8'sd3;
      endcase
      return val;
   endfunction

   // 2-bit Q code: -1, -3, +1, +3
   function automatic logic signed [7:0] code_to_q(input logic [1:0] code);
      logic signed [7:0] val;
      case (code)
         2'd0:    val = -8'sd1;
         2'd1:    val = -8'sd3;
         2'd2:    val = 8'sd1;
         default: val = 8'sd3;
      endcase
      return val;
   endfunction

endpackage

FILE: src/ifsu_chan_stage.sv
`timescale 1ns / 1ps

module ifsu_chan_stage
   import ifsu_pkg::*;
(
   input  logic              clock,
   input  logic [3:0]        nib,
   input  logic              i_only,
   output logic signed [7:0] samp_i_ff,
   output logic signed [7:0] samp_q_ff
);

   logic signed [7:0] samp_i_in;
   logic signed [7:0] samp_q_in;

   always_comb begin
      samp_i_in = code_to_i(nib[1:0]);
      samp_q_in = i_only ? 8'sd0 : code_to_q(nib[3:2]);
   end

   always_ff @(posedge clock) begin
      samp_i_ff <= samp_i_in;
      samp_q_ff <= samp_q_in;
   end

endmodule

FILE: src/if_sample_unpacker_unit.sv
`timescale 1ns / 1ps

// IF sample unpacker. Takes one sample instant (one or two raw bytes) per
// clock on start and returns four channels of signed 8-bit I/Q plus the
// channel count on rsp_valid. The three register stages (input capture,
// 2-bit code decode, format select) run freely, so busy stays low and a new
// transaction may enter every cycle; throughput is one transaction per
// clock. The receiver cannot stall: each result is shown for exactly one
// cycle. Format and I-only mask are captured with each transaction at
// input, so write them while idle.
module if_sample_unpacker_unit
   import ifsu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [1:0] format_mode_ff;
   logic [3:0] i_only_mask_ff;

   logic       s1_valid_ff;
   req_type    s1_data_ff;
   logic [1:0] s1_mode_ff;
   logic [3:0] s1_mask_ff;

   logic              s2_valid_ff;
   logic [1:0]        s2_mode_ff;
   logic signed [7:0] s2_byte_i_ff;
   logic signed [7:0] s2_neg_q_ff;
   logic signed [7:0] s2_pk_i [4];
   logic signed [7:0] s2_pk_q [4];
   logic signed [7:0] s2_neg_q_in;

   rsp_type rsp_data_in;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_mode_ff <= MODE_INT8;
         i_only_mask_ff <= 4'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FORMAT_MODE: format_mode_ff <= csr_wdata[1:0];
            CSR_I_ONLY_MASK: i_only_mask_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // stage 1: capture transaction with its config
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= req_data;
      s1_mode_ff <= format_mode_ff;
      s1_mask_ff <= i_only_mask_ff;
   end

   // stage 2: decode every nibble, negate second byte (wraps at -128)
   ifsu_chan_stage u_ch0 (
      .clock     (clock),
      .nib       (s1_data_ff.raw_first[3:0]),
      .i_only    (s1_mask_ff[0]),
      .samp_i_ff (s2_pk_i[0]),
      .samp_q_ff (s2_pk_q[0])
   );

   ifsu_chan_stage u_ch1 (
      .clock     (clock),
      .nib       (s1_data_ff.raw_first[7:4]),
      .i_only    (s1_mask_ff[1]),
      .samp_i_ff (s2_pk_i[1]),
      .samp_q_ff (s2_pk_q[1])
   );

   ifsu_chan_stage u_ch2 (
      .clock     (clock),
      .nib       (s1_data_ff.raw_second[3:0]),
      .i_only    (s1_mask_ff[2]),
      .samp_i_ff (s2_pk_i[2]),
      .samp_q_ff (s2_pk_q[2])
   );

   ifsu_chan_stage u_ch3 (
      .clock     (clock),
      .nib       (s1_data_ff.raw_second[7:4]),
      .i_only    (s1_mask_ff[3]),
      .samp_i_ff (s2_pk_i[3]),
      .samp_q_ff (s2_pk_q[3])
   );

   assign s2_neg_q_in = 8'sd0 - $signed(s1_data_ff.raw_second);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_mode_ff   <= s1_mode_ff;
      s2_byte_i_ff <= $signed(s1_data_ff.raw_first);
      s2_neg_q_ff  <= s2_neg_q_in;
   end

   // stage 3: select by format, zero unused channels
   always_comb begin
      rsp_data_in = '0;
      unique case (s2_mode_ff)
         MODE_INT8: begin
            rsp_data_in.ch0_i         = s2_byte_i_ff;
            rsp_data_in.channel_count = CHAN_COUNT_ONE;
         end
         MODE_COMPLEX: begin
            rsp_data_in.ch0_i         = s2_byte_i_ff;
            rsp_data_in.ch0_q         = s2_neg_q_ff;
            rsp_data_in.channel_count = CHAN_COUNT_ONE;
         end
         MODE_PACK2: begin
            rsp_data_in.ch0_i         = s2_pk_i[0];
            rsp_data_in.ch0_q         = s2_pk_q[0];
            rsp_data_in.ch1_i         = s2_pk_i[1];
            rsp_data_in.ch1_q         = s2_pk_q[1];
            rsp_data_in.channel_count = CHAN_COUNT_TWO;
         end
         MODE_PACK4: begin
            rsp_data_in.ch0_i         = s2_pk_i[0];
            rsp_data_in.ch0_q         = s2_pk_q[0];
            rsp_data_in.ch1_i         = s2_pk_i[1];
            rsp_data_in.ch1_q         = s2_pk_q[1];
            rsp_data_in.ch2_i         = s2_pk_i[2];
            rsp_data_in.ch2_q         = s2_pk_q[2];
            rsp_data_in.ch3_i         = s2_pk_i[3];
            rsp_data_in.ch3_q         = s2_pk_q[3];
            rsp_data_in.channel_count = CHAN_COUNT_FOUR;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
